// ===== sv/bba_pkg.sv =====
// Shared types and constants of the buddy bitmap allocator.
package bba_pkg;

    localparam int REQ_W  = 31;
    localparam int IDX_W  = 16;
    localparam int LVL_W  = 4;
    localparam int ST_W   = 3;
    localparam int OFF_W  = 31;
    localparam int MINB_W = 17;
    localparam int HDR_W  = 8;
    localparam int CFGI_W = 2;
    localparam int SIZE_W = 32;
    localparam int TOTB_W = 32;
    localparam int SZSH_W = 48;

    localparam logic [CFGI_W-1:0] REG_LEVEL_COUNT = 2'd0;
    localparam logic [CFGI_W-1:0] REG_MIN_BLOCK   = 2'd1;
    localparam logic [CFGI_W-1:0] REG_HEADER      = 2'd2;

    localparam logic [ST_W-1:0] ST_OK          = 3'd0;
    localparam logic [ST_W-1:0] ST_ZERO        = 3'd1;
    localparam logic [ST_W-1:0] ST_TOO_LARGE   = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_FREE     = 3'd3;
    localparam logic [ST_W-1:0] ST_DOUBLE_FREE = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD_INDEX   = 3'd5;

    localparam logic [1:0] RD_SCAN  = 2'd0;
    localparam logic [1:0] RD_IDX   = 2'd1;
    localparam logic [1:0] RD_BUDDY = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;

    typedef struct packed {
        logic            load;
        logic            clr_step;
        logic            lvl_init;
        logic            lvl_step;
        logic            scan_init;
        logic            scan_next;
        logic            found;
        logic            fr_ok;
        logic            sub_step;
        logic            anc_step;
        logic            fw_step;
        logic [1:0]      rd_sel;
        logic            out_load;
        logic            out_fill;
        logic [ST_W-1:0] out_status;
    } bba_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic zero_req;
        logic too_large;
        logic bad_idx;
        logic lvl_more;
        logic scan_last;
        logic rd_bit;
        logic sub_last;
        logic cur_root;
        logic out_busy;
    } bba_sts_t;

endpackage

// ===== sv/bba_dp.sv =====
// Datapath of the buddy bitmap allocator: used-bit memory, walkers and result register.
module bba_dp
    import bba_pkg::*;
#(
    parameter int MAX_LEVEL_LIMIT = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  bba_cmd_t            cmd,
    output bba_sts_t            sts,
    input  logic                cfg_we,
    input  logic [CFGI_W-1:0]   cfg_index,
    input  logic [MINB_W-1:0]   cfg_data,
    input  logic                action,
    input  logic [REQ_W-1:0]    request_bytes,
    input  logic [IDX_W-1:0]    node_index,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [ST_W-1:0]     status,
    output logic [OFF_W-1:0]    block_offset,
    output logic [IDX_W-1:0]    block_node,
    output logic [LVL_W-1:0]    block_level
);

    localparam int NW    = MAX_LEVEL_LIMIT;
    localparam int DEPTH = (1 << MAX_LEVEL_LIMIT) - 1;
    localparam int PW    = NW + MINB_W;
    localparam int SHW   = PW + 15;
    localparam int CW    = (NW + 1 > IDX_W) ? NW + 1 : IDX_W;

    logic [LVL_W-1:0]  lvl_cnt_reg;
    logic [MINB_W-1:0] min_blk_reg;
    logic [HDR_W-1:0]  hdr_reg;

    logic              act_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [NW-1:0]     node_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [SZSH_W-1:0] szsh_reg;
    logic [NW:0]       i_reg;
    logic [NW:0]       lo_reg;
    logic [NW:0]       hi_reg;
    logic [NW:0]       k_reg;
    logic              sub_val_reg;
    logic [NW-1:0]     cur_reg;
    logic [PW-1:0]     prod_reg;
    logic [NW-1:0]     clr_cnt_reg;

    logic              mem [DEPTH];
    logic              rdata_reg;

    logic              out_valid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic [IDX_W-1:0]  bnode_reg;
    logic [LVL_W-1:0]  blevel_reg;

    logic [LVL_W-1:0]  n_eff;
    logic [NW:0]       total_nodes;
    logic [TOTB_W-1:0] total_bytes;
    logic [SIZE_W-1:0] size_w;
    logic [NW:0]       first_w;
    logic [NW:0]       last_m1_w;
    logic [NW:0]       lo_step;
    logic [NW:0]       hi_step;
    logic [NW-1:0]     parent_w;
    logic [NW-1:0]     buddy_w;
    logic [NW-1:0]     raddr;
    logic [NW-1:0]     waddr;
    logic              wdata;
    logic              we;
    logic [LVL_W-1:0]  sh_w;
    logic [OFF_W-1:0]  off_w;

    assign n_eff = (32'(lvl_cnt_reg) > 32'(MAX_LEVEL_LIMIT - 1))
                   ? LVL_W'(MAX_LEVEL_LIMIT - 1) : lvl_cnt_reg;
    // shift amounts carry one extra bit so that level 15 plus one does not wrap
    assign total_nodes = ((NW + 1)'(1) << ({1'b0, n_eff} + (LVL_W + 1)'(1))) - 1'b1;
    assign total_bytes = TOTB_W'(min_blk_reg) << n_eff;
    assign size_w      = SIZE_W'(req_reg) + SIZE_W'(hdr_reg);
    assign first_w     = ((NW + 1)'(1) << lvl_reg) - 1'b1;
    assign last_m1_w   = ((NW + 1)'(1) << ({1'b0, lvl_reg} + (LVL_W + 1)'(1)))
                         - (NW + 1)'(2);
    assign lo_step     = {lo_reg[NW-1:0], 1'b1};
    assign hi_step     = {hi_reg[NW-1:0], 1'b0} + (NW + 1)'(2);
    assign parent_w    = (cur_reg - 1'b1) >> 1;
    assign buddy_w     = cur_reg[0] ? cur_reg + 1'b1 : cur_reg - 1'b1;
    assign sh_w        = n_eff - lvl_reg;
    assign off_w       = OFF_W'(SHW'(prod_reg) << sh_w);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SCAN:  raddr = i_reg[NW-1:0];
            RD_IDX:   raddr = node_reg;
            RD_BUDDY: raddr = buddy_w;
            default:  raddr = i_reg[NW-1:0];
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = clr_cnt_reg;
        wdata = 1'b0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        else if (cmd.sub_step)
        begin
            we    = 1'b1;
            waddr = k_reg[NW-1:0];
            wdata = sub_val_reg;
        end
        else if (cmd.anc_step)
        begin
            we    = 1'b1;
            waddr = parent_w;
            wdata = 1'b1;
        end
        else if (cmd.fw_step)
        begin
            we    = 1'b1;
            waddr = parent_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_cnt_reg <= LVL_W'(10);
            min_blk_reg <= MINB_W'(16);
            hdr_reg     <= HDR_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVEL_COUNT: lvl_cnt_reg <= cfg_data[LVL_W-1:0];
                REG_MIN_BLOCK:   min_blk_reg <= cfg_data;
                REG_HEADER:      hdr_reg     <= cfg_data[HDR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            req_reg  <= request_bytes;
            idx_reg  <= node_index;
            node_reg <= NW'(node_index);
            cur_reg  <= NW'(node_index);
        end
        if (cmd.lvl_init)
        begin
            lvl_reg  <= '0;
            szsh_reg <= SZSH_W'(size_w) << 1;
        end
        else if (cmd.lvl_step)
        begin
            lvl_reg  <= lvl_reg + 1'b1;
            szsh_reg <= szsh_reg << 1;
        end
        if (cmd.scan_init)
        begin
            i_reg <= first_w;
        end
        else if (cmd.scan_next)
        begin
            i_reg <= i_reg + 1'b1;
        end
        if (cmd.found)
        begin
            node_reg    <= i_reg[NW-1:0];
            cur_reg     <= i_reg[NW-1:0];
            lo_reg      <= i_reg;
            hi_reg      <= i_reg;
            k_reg       <= i_reg;
            sub_val_reg <= 1'b1;
            prod_reg    <= PW'(NW'(i_reg - first_w)) * PW'(min_blk_reg);
        end
        else if (cmd.fr_ok)
        begin
            lo_reg      <= (NW + 1)'(node_reg);
            hi_reg      <= (NW + 1)'(node_reg);
            k_reg       <= (NW + 1)'(node_reg);
            sub_val_reg <= 1'b0;
        end
        else if (cmd.sub_step)
        begin
            if (k_reg == hi_reg)
            begin
                lo_reg <= lo_step;
                hi_reg <= hi_step;
                k_reg  <= lo_step;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
        if (cmd.anc_step || cmd.fw_step)
        begin
            cur_reg <= parent_w;
        end
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            if (cmd.out_fill)
            begin
                offset_reg <= off_w;
                bnode_reg  <= IDX_W'(node_reg);
                blevel_reg <= lvl_reg;
            end
            else
            begin
                offset_reg <= '0;
                bnode_reg  <= '0;
                blevel_reg <= '0;
            end
        end
    end

    assign sts.clr_done  = (clr_cnt_reg == NW'(DEPTH - 1));
    assign sts.is_free   = (act_reg != ACT_ALLOC);
    assign sts.zero_req  = (req_reg == '0);
    assign sts.too_large = (size_w > total_bytes);
    assign sts.bad_idx   = (CW'(idx_reg) >= CW'(total_nodes));
    assign sts.lvl_more  = (lvl_reg < n_eff) && (szsh_reg <= SZSH_W'(total_bytes));
    assign sts.scan_last = (i_reg == last_m1_w);
    assign sts.rd_bit    = rdata_reg;
    assign sts.sub_last  = (k_reg == hi_reg) && (lo_step >= total_nodes);
    assign sts.cur_root  = (cur_reg == '0);
    assign sts.out_busy  = out_valid_reg && out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign block_offset = offset_reg;
    assign block_node   = bnode_reg;
    assign block_level  = blevel_reg;

endmodule

// ===== sv/bba_ctrl.sv =====
// Sequencer of the buddy bitmap allocator.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  bba_sts_t sts,
    output bba_cmd_t cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_LVL  = 4'd3;
    localparam logic [3:0] S_SCRD = 4'd4;
    localparam logic [3:0] S_SCCK = 4'd5;
    localparam logic [3:0] S_SUB  = 4'd6;
    localparam logic [3:0] S_ANC  = 4'd7;
    localparam logic [3:0] S_FRCK = 4'd8;
    localparam logic [3:0] S_FWRD = 4'd9;
    localparam logic [3:0] S_FWCK = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]      state_reg;
    logic [3:0]      state_next;
    logic [ST_W-1:0] st_reg;
    logic [ST_W-1:0] st_next;
    logic            fill_reg;
    logic            fill_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        fill_next  = fill_reg;
        cmd        = '0;
        cmd.rd_sel = RD_SCAN;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    fill_next  = 1'b0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.rd_sel = RD_IDX;
                if (sts.is_free)
                begin
                    if (sts.bad_idx)
                    begin
                        st_next    = ST_BAD_INDEX;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_FRCK;
                    end
                end
                else if (sts.zero_req)
                begin
                    st_next    = ST_ZERO;
                    state_next = S_FIN;
                end
                else if (sts.too_large)
                begin
                    st_next    = ST_TOO_LARGE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.lvl_init = 1'b1;
                    state_next   = S_LVL;
                end
            end
            S_LVL:
            begin
                if (sts.lvl_more)
                begin
                    cmd.lvl_step = 1'b1;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCRD;
                end
            end
            S_SCRD:
            begin
                state_next = S_SCCK;
            end
            S_SCCK:
            begin
                if (!sts.rd_bit)
                begin
                    cmd.found  = 1'b1;
                    state_next = S_SUB;
                end
                else if (sts.scan_last)
                begin
                    st_next    = ST_NO_FREE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCRD;
                end
            end
            S_SUB:
            begin
                cmd.sub_step = 1'b1;
                if (sts.sub_last)
                begin
                    state_next = sts.is_free ? S_FWRD : S_ANC;
                end
            end
            S_ANC:
            begin
                if (sts.cur_root)
                begin
                    st_next    = ST_OK;
                    fill_next  = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.anc_step = 1'b1;
                end
            end
            S_FRCK:
            begin
                if (!sts.rd_bit)
                begin
                    st_next    = ST_DOUBLE_FREE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.fr_ok  = 1'b1;
                    state_next = S_SUB;
                end
            end
            S_FWRD:
            begin
                cmd.rd_sel = RD_BUDDY;
                if (sts.cur_root)
                begin
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_FWCK;
                end
            end
            S_FWCK:
            begin
                if (sts.rd_bit)
                begin
                    st_next    = ST_OK;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.fw_step = 1'b1;
                    state_next  = S_FWRD;
                end
            end
            S_FIN:
            begin
                // hold until the result register is free
                if (!sts.out_busy)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_fill   = fill_reg;
                    cmd.out_status = st_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            st_reg    <= ST_OK;
            fill_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// ===== sv/buddy_bitmap_allocator_unit.sv =====
// Top level of the buddy bitmap allocator.
//
// channel  direction  handshake            payload
// in       input      in_valid/in_stall    action, request_bytes, node_index
// out      output     out_valid/out_stall  status, block_offset, block_node, block_level
// cfg      input      cfg_we               cfg_index, cfg_data
//
// After reset a clearing pass writes all 2^MAX_LEVEL_LIMIT-1 used bits, one per
// cycle, with in_stall high. One transaction is worked at a time: an allocate goes
// through decode, level search, node scan, subtree and ancestor marking; a free
// through decode, used-bit check, subtree clearing and buddy checks up the tree.
// A new transaction is taken while a result waits in the output register.
module buddy_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_LEVEL_LIMIT = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [REQ_W-1:0]   request_bytes,
    input  logic [IDX_W-1:0]   node_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ST_W-1:0]    status,
    output logic [OFF_W-1:0]   block_offset,
    output logic [IDX_W-1:0]   block_node,
    output logic [LVL_W-1:0]   block_level,
    input  logic               cfg_we,
    input  logic [CFGI_W-1:0]  cfg_index,
    input  logic [MINB_W-1:0]  cfg_data
);

    bba_cmd_t cmd;
    bba_sts_t sts;

    bba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_dp
    #(
        .MAX_LEVEL_LIMIT (MAX_LEVEL_LIMIT)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (action),
        .request_bytes (request_bytes),
        .node_index    (node_index),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .block_offset  (block_offset),
        .block_node    (block_node),
        .block_level   (block_level)
    );

endmodule

// ===== test/tb_buddy_bitmap_allocator_unit.sv =====
// Testbench for the buddy bitmap allocator: directed and random allocate/free traffic.
`timescale 1ns / 1ps

module tb_buddy_bitmap_allocator_unit;
    import bba_pkg::*;

    localparam int LEVEL_LIMIT = 16;
    localparam int NODE_SLOTS  = (1 << LEVEL_LIMIT) - 1;
    localparam longint CYCLE_LIMIT = 64'd60000000;

    typedef struct packed {
        logic               act;
        logic [REQ_W-1:0]   bytes;
        logic [IDX_W-1:0]   node;
    } alloc_req_t;

    typedef struct packed {
        logic [ST_W-1:0]  st;
        logic [OFF_W-1:0] off;
        logic [IDX_W-1:0] node;
        logic [LVL_W-1:0] lvl;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic action = 1'b0;
    logic [REQ_W-1:0] request_bytes = '0;
    logic [IDX_W-1:0] node_index = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ST_W-1:0] status;
    logic [OFF_W-1:0] block_offset;
    logic [IDX_W-1:0] block_node;
    logic [LVL_W-1:0] block_level;
    logic cfg_we = 1'b0;
    logic [CFGI_W-1:0] cfg_index = '0;
    logic [MINB_W-1:0] cfg_data = '0;

    buddy_bitmap_allocator_unit dut (.*);

    always #5 clk = ~clk;

    // predictor state
    bit         used_bits [NODE_SLOTS];
    logic [3:0] lvl_cfg;
    logic [16:0] minb_cfg;
    logic [7:0] hdr_cfg;

    alloc_req_t pending_reqs [$];
    alloc_rsp_t expected_rsps [$];
    int  errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  status_seen [8];
    bit  calm = 1'b0;       // no random idling
    bit  hold_rx = 1'b0;    // long receiver hold-off request
    bit  pause_tx = 1'b0;
    longint cycles = 0;
    logic [IDX_W-1:0] live_nodes [$];

    function automatic int eff_levels();
        return (lvl_cfg > LEVEL_LIMIT - 1) ? LEVEL_LIMIT - 1 : int'(lvl_cfg);
    endfunction

    function automatic void set_subtree(int root, bit v);
        longint lo, hi, k, total;
        total = (64'd1 << (eff_levels() + 1)) - 1;
        lo = root;
        hi = root;
        while (lo < total)
        begin
            for (k = lo; k <= hi && k < total; k++)
                used_bits[k] = v;
            lo = 2 * lo + 1;
            hi = 2 * hi + 2;
        end
    endfunction

    function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
        alloc_rsp_t o;
        int n, lvl, first, last, i, cur, buddy, parent;
        longint total, sz;
        bit found;
        o = '0;
        n = eff_levels();
        if (r.act == ACT_ALLOC)
        begin
            total = longint'(minb_cfg) << n;
            sz = longint'(r.bytes) + hdr_cfg;
            if (r.bytes == 0)
                o.st = ST_ZERO;
            else if (sz > total)
                o.st = ST_TOO_LARGE;
            else
            begin
                lvl = 0;
                while (lvl < n && (sz << (lvl + 1)) <= total)
                    lvl++;
                first = (1 << lvl) - 1;
                last = (1 << (lvl + 1)) - 1;
                found = 1'b0;
                for (i = first; i < last; i++)
                    if (!used_bits[i])
                    begin
                        found = 1'b1;
                        break;
                    end
                if (!found)
                    o.st = ST_NO_FREE;
                else
                begin
                    set_subtree(i, 1'b1);
                    cur = i;
                    while (cur != 0)
                    begin
                        cur = (cur - 1) / 2;
                        used_bits[cur] = 1'b1;
                    end
                    o.st = ST_OK;
                    o.off = OFF_W'(longint'(i - first) * (longint'(minb_cfg) << (n - lvl)));
                    o.node = IDX_W'(i);
                    o.lvl = LVL_W'(lvl);
                end
            end
        end
        else
        begin
            if (int'(r.node) >= (1 << (n + 1)) - 1)
                o.st = ST_BAD_INDEX;
            else if (!used_bits[r.node])
                o.st = ST_DOUBLE_FREE;
            else
            begin
                o.st = ST_OK;
                set_subtree(r.node, 1'b0);
                cur = r.node;
                while (cur != 0)
                begin
                    buddy = (cur & 1) ? cur + 1 : cur - 1;
                    parent = (cur - 1) / 2;
                    if (used_bits[buddy])
                        break;
                    used_bits[parent] = 1'b0;
                    cur = parent;
                end
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
        errors++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            cycles <= cycles + 1;
            if (!in_valid || !in_stall)
            begin
                if (in_valid)
                begin
                    expected_rsps.push_back(predict_alloc({action, request_bytes, node_index}));
                    n_sent++;
                end
                if (pending_reqs.size() > 0 && !pause_tx
                    && (calm || $urandom_range(99) >= 11))
                begin
                    alloc_req_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    action <= r.act;
                    request_bytes <= r.bytes;
                    node_index <= r.node;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected result status", status, 0);
                end
                else
                begin
                    alloc_rsp_t e;
                    e = expected_rsps.pop_front();
                    if (status !== e.st)
                        report_mismatch("status", status, e.st);
                    if (block_offset !== e.off)
                        report_mismatch("block_offset", block_offset, e.off);
                    if (block_node !== e.node)
                        report_mismatch("block_node", block_node, e.node);
                    if (block_level !== e.lvl)
                        report_mismatch("block_level", block_level, e.lvl);
                    if (e.st == ST_OK && e.lvl != 0 || e.node != 0)
                        live_nodes.push_back(e.node);
                    status_seen[e.st]++;
                    n_checked++;
                end
            end
            out_stall <= hold_rx || (!calm && $urandom_range(99) < 11);
        end
    end

    // long receiver hold-off, counted in its own process
    task automatic hold_receiver(int len);
        hold_rx = 1'b1;
        repeat (len) @(posedge clk);
        hold_rx = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [MINB_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_LEVEL_COUNT)
            lvl_cfg = val[3:0];
        else if (idx == REG_MIN_BLOCK)
            minb_cfg = val;
        else
            hdr_cfg = val[7:0];
    endtask

    task automatic push_req(logic act, logic [REQ_W-1:0] bytes, logic [IDX_W-1:0] node);
        pending_reqs.push_back({act, bytes, node});
    endtask

    // mostly well-formed traffic: allocs of fitting sizes, frees of granted nodes
    task automatic random_phase(int count);
        int k, lvls;
        longint total;
        logic [IDX_W-1:0] nd;
        for (k = 0; k < count; k++)
        begin
            lvls = eff_levels();
            total = longint'(minb_cfg) << lvls;
            case ($urandom_range(9))
                0, 1, 2, 3:
                    push_req(ACT_ALLOC, REQ_W'($urandom_range(1,
                        (total > 64'd2000000) ? 2000000 : ((total < 2) ? 1 : int'(total)))), 0);
                4, 5, 6:
                    if (live_nodes.size() > 0)
                    begin
                        nd = live_nodes[$urandom_range(live_nodes.size() - 1)];
                        push_req(1'b1, REQ_W'($urandom), nd);
                    end
                    else
                        push_req(1'b1, 0, IDX_W'($urandom_range((2 << lvls) - 2)));
                7:
                    push_req(1'b1, REQ_W'($urandom), IDX_W'($urandom_range((2 << lvls) - 2)));
                8:
                    push_req(ACT_ALLOC, REQ_W'($urandom), IDX_W'($urandom));
                default:
                    push_req(1'($urandom_range(1)), REQ_W'($urandom_range(3)),
                             IDX_W'($urandom));
            endcase
            // keep the queue short so frees see recent grants
            while (pending_reqs.size() > 4)
                @(posedge clk);
        end
    endtask

    initial
    begin
        lvl_cfg = 4'd10;
        minb_cfg = 17'd16;
        hdr_cfg = 8'd8;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, extremes and special cases
        push_req(ACT_ALLOC, 0, 0);
        push_req(ACT_ALLOC, REQ_W'(32'h7FFFFFFF), 0);
        push_req(ACT_ALLOC, 16376, 0);
        push_req(ACT_ALLOC, 1, 0);
        push_req(ACT_ALLOC, 8, 0);
        push_req(ACT_ALLOC, 500, 0);
        push_req(1'b1, 0, 16'hFFFF);
        push_req(1'b1, 0, 16'd2047);
        push_req(1'b1, 0, 16'd2046);
        push_req(1'b1, 0, 16'd1023);
        push_req(1'b1, 0, 16'd1023);
        push_req(1'b1, 0, 16'd0);
        push_req(1'b1, 0, 16'd0);
        push_req(ACT_ALLOC, 16376, 0);
        push_req(ACT_ALLOC, 1, 0);
        push_req(1'b1, REQ_W'(32'h7FFFFFFF), 16'd1);
        push_req(1'b1, 0, 16'd0);
        wait_drained();

        write_reg(REG_LEVEL_COUNT, 17'd15);
        write_reg(REG_MIN_BLOCK, 17'd65536);
        write_reg(REG_HEADER, 17'd255);
        push_req(ACT_ALLOC, 1, 0);          // deepest level, wide offset
        push_req(ACT_ALLOC, 1, 0);
        push_req(1'b1, 0, 16'd65534);
        push_req(1'b1, 0, 16'd32767);
        push_req(ACT_ALLOC, REQ_W'(32'h7FFFFFFF), 0);
        wait_drained();
        write_reg(REG_LEVEL_COUNT, 17'd3);  // level change keeps used bits
        push_req(1'b1, 0, 16'd15);
        push_req(1'b1, 0, 16'd0);
        wait_drained();
        write_reg(REG_MIN_BLOCK, 17'd0);
        push_req(ACT_ALLOC, 5, 0);
        push_req(ACT_ALLOC, 0, 0);
        wait_drained();
        write_reg(REG_LEVEL_COUNT, 17'd0);
        write_reg(REG_MIN_BLOCK, 17'd1);
        write_reg(REG_HEADER, 17'd0);
        push_req(ACT_ALLOC, 1, 0);
        push_req(ACT_ALLOC, 1, 0);
        push_req(1'b1, 0, 16'd0);
        push_req(1'b1, 0, 16'd1);
        wait_drained();

        // random phases over several settings
        calm = 1'b1;
        write_reg(REG_LEVEL_COUNT, 17'd4);
        write_reg(REG_MIN_BLOCK, 17'd16);
        write_reg(REG_HEADER, 17'd4);
        live_nodes.delete();
        fork
            random_phase(150);
            hold_receiver(3000);
        join
        wait_drained();
        calm = 1'b0;
        pause_tx = 1'b1;
        wait_drained();
        pause_tx = 1'b0;
        random_phase(400);
        wait_drained();

        write_reg(REG_LEVEL_COUNT, 17'd6);
        write_reg(REG_MIN_BLOCK, 17'd100);
        write_reg(REG_HEADER, 17'd255);
        random_phase(400);
        wait_drained();

        write_reg(REG_LEVEL_COUNT, 17'd2);
        write_reg(REG_MIN_BLOCK, 17'd65536);
        write_reg(REG_HEADER, 17'd0);
        random_phase(300);
        wait_drained();

        write_reg(REG_LEVEL_COUNT, 17'd8);
        write_reg(REG_MIN_BLOCK, 17'd3);
        write_reg(REG_HEADER, 17'd17);
        random_phase(280);
        wait_drained();

        $display("Sent %0d transactions over levels 0 to 15, %0d results checked", n_sent,
                 n_checked);
        $display("Results: ok %0d, zero %0d, too large %0d, no free %0d, double %0d, bad %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
sv/bba_pkg.sv
sv/bba_dp.sv
sv/bba_ctrl.sv
sv/buddy_bitmap_allocator_unit.sv
test/tb_buddy_bitmap_allocator_unit.sv
